[rtl/btst_pkg.sv]
// Shared types and codes for the best-time sorted table.
package btst_pkg;

  localparam int KEY_W  = 24;
  localparam int TIME_W = 32;

  // Command codes
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_IGNORED  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_READ_OK  = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] lap;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_PLACE,
    S_RD,
    S_RDW,
    S_OUT
  } state_t;

endpackage

[rtl/btst_if.sv]
// Handshake channel interfaces for command items and result items.
interface btst_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  command;
  logic [btst_pkg::KEY_W-1:0]  driver_code;
  logic [btst_pkg::TIME_W-1:0] lap_time;
  logic [3:0]                  rank;

  modport source (output valid, command, driver_code, lap_time, rank, input ready);
  modport sink   (input valid, command, driver_code, lap_time, rank, output ready);
endinterface

interface btst_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [btst_pkg::KEY_W-1:0]  entry_key;
  logic [btst_pkg::TIME_W-1:0] entry_time;
  logic [3:0]                  entry_rank;
  logic [4:0]                  entry_count;

  modport source (output valid, status, entry_key, entry_time, entry_rank, entry_count,
                  input ready);
  modport sink   (input valid, status, entry_key, entry_time, entry_rank, entry_count,
                  output ready);
endinterface

[rtl/best_time_sorted_table.sv]
// Top level of the best-time sorted table.
// Holds up to CAPACITY entries (key, time) in one single-port-write memory, sorted by
// ascending time, with a fill count so no clearing pass is needed after reset. One item
// is taken at a time and exactly one result item follows it. An add scans the held
// entries one per cycle (key lookup and insertion rank together), then moves the
// entries between the old and new place one per cycle and writes the new entry.
// The scan and move rate is set by the memory's one read and one write port. A read
// fetches the entry at its rank from the memory before its result; a clear, a read past
// the end or an unused code goes straight to its result. Every result waits on the result side.
module best_time_sorted_table #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  btst_in_if.sink       in_ch,
  btst_out_if.source    out_ch
);

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  btst_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]               chk_idx_r, chk_idx_nxt;
  logic                        found_r, found_nxt;
  logic [IW-1:0]               f_r, f_nxt;
  logic [btst_pkg::TIME_W-1:0] ftime_r, ftime_nxt;
  logic [CW-1:0]               le_r, le_nxt;
  logic [IW-1:0]               p_r, p_nxt;
  logic                        down_r, down_nxt;
  logic [IW-1:0]               dst_r, dst_nxt;
  logic                        pend_r, pend_nxt;
  logic [IW-1:0]               pwaddr_r, pwaddr_nxt;
  logic                        new_r, new_nxt;
  logic [btst_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [btst_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [3:0]                  rank_r, rank_nxt;

  logic [2:0]                  res_status_r, res_status_nxt;
  logic [btst_pkg::KEY_W-1:0]  res_key_r, res_key_nxt;
  logic [btst_pkg::TIME_W-1:0] res_time_r, res_time_nxt;
  logic [3:0]                  res_rank_r, res_rank_nxt;
  logic [4:0]                  res_count_r, res_count_nxt;

  btst_pkg::entry_t            mem [CAPACITY];
  btst_pkg::entry_t            rdata_r;
  logic [IW-1:0]               raddr;
  logic                        we;
  logic [IW-1:0]               waddr;
  btst_pkg::entry_t            wdata;

  logic in_acc;
  logic out_acc;
  logic rd_ok;
  logic ignore_add;
  logic full_add;
  logic equal_time;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign out_acc    = out_ch.valid && out_ch.ready;
  assign rd_ok      = CMPW'(in_ch.rank) < CMPW'(count_r);
  assign equal_time = (ftime_r == time_r);
  assign ignore_add = found_r && (ftime_r < time_r);
  assign full_add   = !found_r && (count_r >= CW'(CAPACITY));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      btst_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == btst_pkg::CMD_ADD) begin
            state_nxt = btst_pkg::S_SCAN;
          end else if (in_ch.command == btst_pkg::CMD_READ && rd_ok) begin
            state_nxt = btst_pkg::S_RD;
          end else begin
            state_nxt = btst_pkg::S_OUT;
          end
        end
      end
      btst_pkg::S_SCAN: begin
        if (idx_r >= count_r && !chk_vld_r) state_nxt = btst_pkg::S_DECIDE;
      end
      btst_pkg::S_DECIDE: begin
        if (ignore_add || full_add) state_nxt = btst_pkg::S_OUT;
        else                        state_nxt = btst_pkg::S_SHIFT;
      end
      btst_pkg::S_SHIFT: begin
        if (dst_r == p_r && !pend_r) state_nxt = btst_pkg::S_PLACE;
      end
      btst_pkg::S_PLACE: state_nxt = btst_pkg::S_OUT;
      btst_pkg::S_RD:    state_nxt = btst_pkg::S_RDW;
      btst_pkg::S_RDW:   state_nxt = btst_pkg::S_OUT;
      btst_pkg::S_OUT: begin
        if (out_acc) state_nxt = btst_pkg::S_IDLE;
      end
      default: state_nxt = btst_pkg::S_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    found_nxt      = found_r;
    f_nxt          = f_r;
    ftime_nxt      = ftime_r;
    le_nxt         = le_r;
    p_nxt          = p_r;
    down_nxt       = down_r;
    dst_nxt        = dst_r;
    pend_nxt       = pend_r;
    pwaddr_nxt     = pwaddr_r;
    new_nxt        = new_r;
    key_nxt        = key_r;
    time_nxt       = time_r;
    rank_nxt       = rank_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_time_nxt   = res_time_r;
    res_rank_nxt   = res_rank_r;
    res_count_nxt  = res_count_r;
    raddr          = '0;

    case (state_r)
      btst_pkg::S_IDLE: begin
        if (in_acc) begin
          key_nxt       = in_ch.driver_code;
          time_nxt      = in_ch.lap_time;
          rank_nxt      = in_ch.rank;
          idx_nxt       = '0;
          chk_vld_nxt   = 1'b0;
          found_nxt     = 1'b0;
          le_nxt        = '0;
          pend_nxt      = 1'b0;
          res_key_nxt   = '0;
          res_time_nxt  = '0;
          res_rank_nxt  = '0;
          res_count_nxt = 5'(count_r);
          if (in_ch.command == btst_pkg::CMD_READ) begin
            res_status_nxt = btst_pkg::ST_EMPTY;
          end else if (in_ch.command == btst_pkg::CMD_CLEAR) begin
            count_nxt      = '0;
            res_status_nxt = btst_pkg::ST_EMPTY;
            res_count_nxt  = '0;
          end else begin
            res_status_nxt = btst_pkg::ST_IGNORED;
          end
        end
      end
      btst_pkg::S_SCAN: begin
        raddr = IW'(idx_r);
        if (idx_r < count_r) begin
          idx_nxt     = idx_r + CW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = IW'(idx_r);
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r) begin
          if (!found_r && rdata_r.key == key_r) begin
            found_nxt = 1'b1;
            f_nxt     = chk_idx_r;
            ftime_nxt = rdata_r.lap;
          end
          if (rdata_r.lap <= time_r) le_nxt = le_r + CW'(1);
        end
      end
      btst_pkg::S_DECIDE: begin
        res_key_nxt   = key_r;
        res_count_nxt = 5'(count_r);
        if (ignore_add) begin
          res_status_nxt = btst_pkg::ST_IGNORED;
          res_time_nxt   = ftime_r;
          res_rank_nxt   = 4'(f_r);
        end else if (full_add) begin
          res_status_nxt = btst_pkg::ST_FULL;
          res_time_nxt   = time_r;
          res_rank_nxt   = '0;
        end else begin
          // Rank after removal: entries other than the old one with time not above the new time
          new_nxt = !found_r;
          if (found_r) begin
            p_nxt   = IW'(le_r - CW'(equal_time));
            dst_nxt = f_r;
            f_nxt   = f_r;
          end else begin
            p_nxt   = IW'(le_r);
            dst_nxt = IW'(count_r);
            f_nxt   = IW'(count_r);
          end
          down_nxt = (found_r ? IW'(le_r - CW'(equal_time)) : IW'(le_r)) >
                     (found_r ? f_r : IW'(count_r));
        end
      end
      btst_pkg::S_SHIFT: begin
        raddr = down_r ? (dst_r + IW'(1)) : (dst_r - IW'(1));
        if (dst_r != p_r) begin
          pend_nxt   = 1'b1;
          pwaddr_nxt = dst_r;
          dst_nxt    = down_r ? (dst_r + IW'(1)) : (dst_r - IW'(1));
        end else begin
          pend_nxt = 1'b0;
        end
      end
      btst_pkg::S_PLACE: begin
        res_status_nxt = new_r ? btst_pkg::ST_INSERTED : btst_pkg::ST_REPLACED;
        res_key_nxt    = key_r;
        res_time_nxt   = time_r;
        res_rank_nxt   = 4'(p_r);
        if (new_r) begin
          count_nxt     = count_r + CW'(1);
          res_count_nxt = 5'(count_r + CW'(1));
        end else begin
          res_count_nxt = 5'(count_r);
        end
      end
      btst_pkg::S_RD: begin
        raddr = IW'(rank_r);
      end
      btst_pkg::S_RDW: begin
        res_status_nxt = btst_pkg::ST_READ_OK;
        res_key_nxt    = rdata_r.key;
        res_time_nxt   = rdata_r.lap;
        res_rank_nxt   = rank_r;
        res_count_nxt  = 5'(count_r);
      end
      default: begin
      end
    endcase
  end

  // Memory write: shifted entry during a move, new entry at its rank
  assign we    = pend_r || (state_r == btst_pkg::S_PLACE);
  assign waddr = pend_r ? pwaddr_r : p_r;
  assign wdata = pend_r ? rdata_r : btst_pkg::entry_t'{key: key_r, lap: time_r};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= btst_pkg::S_IDLE;
      count_r   <= '0;
      chk_vld_r <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      chk_vld_r <= chk_vld_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    found_r      <= found_nxt;
    f_r          <= f_nxt;
    ftime_r      <= ftime_nxt;
    le_r         <= le_nxt;
    p_r          <= p_nxt;
    down_r       <= down_nxt;
    dst_r        <= dst_nxt;
    pwaddr_r     <= pwaddr_nxt;
    new_r        <= new_nxt;
    key_r        <= key_nxt;
    time_r       <= time_nxt;
    rank_r       <= rank_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_time_r   <= res_time_nxt;
    res_rank_r   <= res_rank_nxt;
    res_count_r  <= res_count_nxt;
  end

  // Outputs
  assign in_ch.ready        = (state_r == btst_pkg::S_IDLE);
  assign out_ch.valid       = (state_r == btst_pkg::S_OUT);
  assign out_ch.status      = res_status_r;
  assign out_ch.entry_key   = res_key_r;
  assign out_ch.entry_time  = res_time_r;
  assign out_ch.entry_rank  = res_rank_r;
  assign out_ch.entry_count = res_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("held count above capacity");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("item taken while a result is pending");

  a_place_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == btst_pkg::S_PLACE) |-> !pend_r)
    else $error("new entry written over a pending move");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.command == btst_pkg::CMD_CLEAR) |=> (count_r == '0))
    else $error("clear left entries held");

endmodule
